// ----- hw/rtl/i2c_master_command_engine_unit_defines.svh -----
// assertion macros for the i2c master command engine
// expects clk and rst in the scope where a macro is used
`ifndef I2C_MASTER_COMMAND_ENGINE_UNIT_DEFINES_SVH
`define I2C_MASTER_COMMAND_ENGINE_UNIT_DEFINES_SVH

// checked after reset has been released
`define I2CM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define I2CM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/i2cm_pkg.sv -----
// types, codes and helper functions for the i2c master command engine
// no dependencies
`timescale 1ns / 1ps

package i2cm_pkg;

  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_SEND  = 3'd2,
    CMD_RACK  = 3'd3,
    CMD_RECV  = 3'd4,
    CMD_SACK  = 3'd5,
    CMD_STOP  = 3'd6
  } cmd_t;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [1:0] REG_CMD    = 2'd0;
  localparam logic [1:0] REG_STATUS = 2'd1;
  localparam logic [1:0] REG_TX     = 2'd2;
  localparam logic [1:0] REG_RX     = 2'd3;

  localparam logic [7:0] CFG_BUS_ENABLE = 8'd0;
  localparam logic [7:0] CFG_SPEED      = 8'd1;

  localparam int STATUS_BUSY_BIT = 7;
  localparam int STATUS_DONE_BIT = 6;
  localparam int CMD_IRQ_EN_BIT  = 7;

  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] reg_select;
    logic [7:0] write_data;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic       irq;
    logic       sda_drive_low;
    logic       scl_drive_low;
    logic [7:0] read_data;
  } res_t;

  // number of scl phases a command runs for, zero for no-op codes
  function automatic logic [4:0] phase_total(logic [2:0] code);
    logic [4:0] n;
    unique case (code)
      CMD_START: n = 5'd3;
      CMD_SEND:  n = 5'd16;
      CMD_RACK:  n = 5'd2;
      CMD_RECV:  n = 5'd16;
      CMD_SACK:  n = 5'd2;
      CMD_STOP:  n = 5'd3;
      default:   n = 5'd0;
    endcase
    return n;
  endfunction

  // pin levels for a phase, returned as {scl, sda}
  function automatic logic [1:0] phase_levels(cmd_t cmd, logic [4:0] ph, logic [7:0] tx,
                                              logic ack, logic scl_cur, logic sda_cur);
    logic scl;
    logic sda;
    scl = scl_cur;
    sda = sda_cur;
    unique case (cmd)
      CMD_START: begin
        scl = (ph < 5'd2);
        sda = (ph == 5'd0);
      end
      CMD_SEND: begin
        scl = ph[0];
        if (!ph[0]) sda = tx[3'd7 - ph[3:1]];
      end
      CMD_RACK, CMD_RECV: begin
        scl = ph[0];
        if (!ph[0]) sda = 1'b1;
      end
      CMD_SACK: begin
        scl = ph[0];
        if (!ph[0]) sda = ack;
      end
      CMD_STOP: begin
        scl = (ph != 5'd0);
        sda = (ph == 5'd2);
      end
      default: begin
      end
    endcase
    return {scl, sda};
  endfunction

endpackage

// ----- hw/rtl/i2cm_core.sv -----
// engine state and per-beat update of the i2c master command engine
// depends on i2cm_pkg and i2c_master_command_engine_unit_defines.svh
`timescale 1ns / 1ps
`include "i2c_master_command_engine_unit_defines.svh"

module i2cm_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  i2cm_pkg::req_t req,
  input  logic          bus_enable,
  input  logic [5:0]    speed_divisor,
  output i2cm_pkg::res_t res
);
  import i2cm_pkg::*;

  cmd_t       active_command, active_command_next;
  logic       irq_enable, irq_enable_next;
  logic [7:0] phase_counter, phase_counter_next;
  logic [4:0] bit_phase, bit_phase_next;
  logic [7:0] transmit_byte, transmit_byte_next;
  logic [7:0] receive_shift, receive_shift_next;
  logic       done_flag, done_flag_next;
  logic       ack_to_send, ack_to_send_next;
  logic       ack_received, ack_received_next;
  logic       scl_level, scl_level_next;
  logic       sda_level, sda_level_next;

  logic [7:0] phase_len;
  logic [7:0] read_value;
  logic [2:0] code;
  logic [1:0] lv;

  assign phase_len = {1'b0, speed_divisor, 1'b0} + 8'd4;
  assign code      = req.write_data[2:0];

  always_comb begin
    read_value = '0;
    if (req.req_type == REQ_READ) begin
      unique case (req.reg_select)
        REG_CMD:    read_value = {irq_enable, 4'd0, active_command};
        REG_STATUS: read_value = {active_command != CMD_IDLE, done_flag, 4'd0,
                                  ack_received, ack_to_send};
        REG_TX:     read_value = transmit_byte;
        default:    read_value = receive_shift;
      endcase
    end
  end

  always_comb begin
    active_command_next = active_command;
    irq_enable_next     = irq_enable;
    phase_counter_next  = phase_counter;
    bit_phase_next      = bit_phase;
    transmit_byte_next  = transmit_byte;
    receive_shift_next  = receive_shift;
    done_flag_next      = done_flag;
    ack_to_send_next    = ack_to_send;
    ack_received_next   = ack_received;
    scl_level_next      = scl_level;
    sda_level_next      = sda_level;
    lv                  = 2'b11;

    // engine advances first
    if (!bus_enable) begin
      active_command_next = CMD_IDLE;
      phase_counter_next  = '0;
      bit_phase_next      = '0;
      scl_level_next      = 1'b1;
      sda_level_next      = 1'b1;
    end else if (active_command != CMD_IDLE) begin
      phase_counter_next = phase_counter + 8'd1;
      if (phase_counter_next >= phase_len) begin
        phase_counter_next = '0;
        // sample at the end of an scl-high phase
        if (bit_phase[0]) begin
          if (active_command == CMD_RACK) ack_received_next = req.sda_in;
          else if (active_command == CMD_RECV)
            receive_shift_next = {receive_shift[6:0], req.sda_in};
        end
        bit_phase_next = bit_phase + 5'd1;
        if (bit_phase_next >= phase_total(active_command)) begin
          if (active_command != CMD_START && active_command != CMD_STOP)
            scl_level_next = 1'b0;
          active_command_next = CMD_IDLE;
          bit_phase_next      = '0;
          done_flag_next      = 1'b1;
        end else begin
          lv = phase_levels(active_command, bit_phase_next, transmit_byte, ack_to_send,
                            scl_level, sda_level);
          scl_level_next = lv[1];
          sda_level_next = lv[0];
        end
      end
    end

    // then the register access
    if (req.req_type == REQ_WRITE) begin
      unique case (req.reg_select)
        REG_CMD: begin
          irq_enable_next = req.write_data[CMD_IRQ_EN_BIT];
          if (bus_enable && active_command_next == CMD_IDLE &&
              phase_total(code) != 5'd0) begin
            active_command_next = cmd_t'(code);
            phase_counter_next  = '0;
            bit_phase_next      = '0;
            lv = phase_levels(cmd_t'(code), 5'd0, transmit_byte, ack_to_send,
                              scl_level_next, sda_level_next);
            scl_level_next = lv[1];
            sda_level_next = lv[0];
          end
        end
        REG_STATUS: begin
          ack_to_send_next = req.write_data[0];
          done_flag_next   = req.write_data[STATUS_DONE_BIT];
        end
        REG_TX:  transmit_byte_next = req.write_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.read_data     = read_value;
    res.scl_drive_low = bus_enable && !scl_level_next;
    res.sda_drive_low = bus_enable && !sda_level_next;
    res.irq           = done_flag_next && irq_enable_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_command <= CMD_IDLE;
      irq_enable     <= 1'b0;
      phase_counter  <= '0;
      bit_phase      <= '0;
      transmit_byte  <= '0;
      receive_shift  <= '0;
      done_flag      <= 1'b0;
      ack_to_send    <= 1'b0;
      ack_received   <= 1'b0;
      scl_level      <= 1'b1;
      sda_level      <= 1'b1;
    end else if (step) begin
      active_command <= active_command_next;
      irq_enable     <= irq_enable_next;
      phase_counter  <= phase_counter_next;
      bit_phase      <= bit_phase_next;
      transmit_byte  <= transmit_byte_next;
      receive_shift  <= receive_shift_next;
      done_flag      <= done_flag_next;
      ack_to_send    <= ack_to_send_next;
      ack_received   <= ack_received_next;
      scl_level      <= scl_level_next;
      sda_level      <= sda_level_next;
    end
  end

  `I2CM_ASSERT(a_idle_counters_clear,
    active_command == CMD_IDLE |-> phase_counter == 8'd0 && bit_phase == 5'd0,
    "idle engine holds a nonzero phase count")
  `I2CM_ASSERT(a_disable_drops_command,
    step && !bus_enable |=> active_command == CMD_IDLE && scl_level && sda_level,
    "command survived a beat with the bus disabled")
  `I2CM_ASSERT(a_done_source,
    $rose(done_flag) |-> $past(step) && ($past(active_command) != CMD_IDLE ||
      ($past(req.req_type) == REQ_WRITE && $past(req.reg_select) == REG_STATUS)),
    "done set without a finished command or status write")

endmodule

// ----- hw/rtl/i2c_master_command_engine_unit.sv -----
// i2c master command engine: one register access or clock tick per beat
// path: a result goes through the input register, then the result register
// throughput: one beat per cycle if not stalled; the engine state updates as a beat enters the result register
// reset: synchronous, active high; config, engine state and both stage valids clear at once
// depends on i2cm_pkg and i2cm_core
`timescale 1ns / 1ps

module i2c_master_command_engine_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] write_data, [8] sda_in, rest zero
  input  logic [3:0]  s_axis_tuser,  // [1:0] req_type, [3:2] reg_select
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [7:0] read_data, [8] scl_drive_low,
                                     // [9] sda_drive_low, [10] irq, rest zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import i2cm_pkg::*;

  logic       bus_enable;
  logic [5:0] speed_divisor;

  logic       in_valid;
  req_t       in_req;
  logic       out_valid;
  res_t       out_res;
  logic       step;
  res_t       core_res;

  assign step          = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || step;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_enable    <= 1'b0;
      speed_divisor <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_BUS_ENABLE) bus_enable <= cfg_data[0];
      else if (cfg_index == CFG_SPEED) speed_divisor <= cfg_data[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_req.req_type   <= s_axis_tuser[1:0];
      in_req.reg_select <= s_axis_tuser[3:2];
      in_req.write_data <= s_axis_tdata[7:0];
      in_req.sda_in     <= s_axis_tdata[8];
    end
  end

  i2cm_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .req           (in_req),
    .bus_enable    (bus_enable),
    .speed_divisor (speed_divisor),
    .res           (core_res)
  );

  // result register, free to refill when the beat in it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) out_res <= core_res;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_res};

endmodule

// ----- dv/i2cm_engine_checker.sv -----
// output checker for the i2c master command engine: keeps its own copy of the
// engine state and config, predicts each output beat and compares in order
// depends on i2cm_pkg
`timescale 1ns / 1ps

module i2cm_engine_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] write_data, [8] sda_in
  input  logic [3:0]  s_axis_tuser,   // [1:0] req_type, [3:2] reg_select
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // [7:0] read_data, [8] scl_drive_low,
                                      // [9] sda_drive_low, [10] irq
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          mismatches,
  output int          outstanding
);
  import i2cm_pkg::*;

  // shadow config
  logic       bus_en;
  logic [5:0] speed;

  // shadow engine state
  cmd_t       active_cmd;
  logic       irq_en;
  logic [7:0] phase_cnt;
  logic [4:0] bit_ph;
  logic [7:0] tx_byte;
  logic [7:0] rx_shift;
  logic       done;
  logic       ack_tx;
  logic       ack_rx;
  logic       scl_lvl;
  logic       sda_lvl;

  res_t engine_outputs_q[$];

  function automatic logic [4:0] num_phases(logic [2:0] code);
    case (code)
      CMD_START, CMD_STOP: return 5'd3;
      CMD_SEND, CMD_RECV:  return 5'd16;
      CMD_RACK, CMD_SACK:  return 5'd2;
      default:             return 5'd0;
    endcase
  endfunction

  // bus levels at the start of phase ph
  task automatic set_levels(input cmd_t c, input logic [4:0] ph);
    case (c)
      CMD_START: begin
        scl_lvl = (ph < 5'd2);
        sda_lvl = (ph == 5'd0);
      end
      CMD_SEND: begin
        scl_lvl = ph[0];
        if (!ph[0]) sda_lvl = tx_byte[3'd7 - ph[3:1]];
      end
      CMD_RACK, CMD_RECV: begin
        scl_lvl = ph[0];
        if (!ph[0]) sda_lvl = 1'b1;
      end
      CMD_SACK: begin
        scl_lvl = ph[0];
        if (!ph[0]) sda_lvl = ack_tx;
      end
      CMD_STOP: begin
        scl_lvl = (ph != 5'd0);
        sda_lvl = (ph == 5'd2);
      end
      default: begin
      end
    endcase
  endtask

  task automatic engine_tick(input logic sda);
    logic [7:0] span;
    span = {1'b0, speed, 1'b0} + 8'd4;
    phase_cnt = phase_cnt + 8'd1;
    if (phase_cnt >= span) begin
      phase_cnt = 8'd0;
      // sample on the last clock of an scl-high phase
      if (bit_ph[0]) begin
        if (active_cmd == CMD_RACK) ack_rx = sda;
        else if (active_cmd == CMD_RECV) rx_shift = {rx_shift[6:0], sda};
      end
      bit_ph = bit_ph + 5'd1;
      if (bit_ph >= num_phases(active_cmd)) begin
        if (active_cmd != CMD_START && active_cmd != CMD_STOP) scl_lvl = 1'b0;
        active_cmd = CMD_IDLE;
        bit_ph = 5'd0;
        done = 1'b1;
      end else begin
        set_levels(active_cmd, bit_ph);
      end
    end
  endtask

  task automatic engine_step(input logic [1:0] req, input logic [1:0] sel,
                             input logic [7:0] wd, input logic sda, output res_t r);
    logic [7:0] rd;
    logic [2:0] code;
    rd = 8'd0;
    // reads see the registers before this beat
    if (req == REQ_READ) begin
      case (sel)
        REG_CMD: begin
          rd[2:0] = active_cmd;
          rd[CMD_IRQ_EN_BIT] = irq_en;
        end
        REG_STATUS: begin
          rd[STATUS_BUSY_BIT] = (active_cmd != CMD_IDLE);
          rd[STATUS_DONE_BIT] = done;
          rd[1] = ack_rx;
          rd[0] = ack_tx;
        end
        REG_TX:  rd = tx_byte;
        default: rd = rx_shift;
      endcase
    end
    if (!bus_en) begin
      active_cmd = CMD_IDLE;
      phase_cnt = 8'd0;
      bit_ph = 5'd0;
      scl_lvl = 1'b1;
      sda_lvl = 1'b1;
    end else if (active_cmd != CMD_IDLE) begin
      engine_tick(sda);
    end
    if (req == REQ_WRITE) begin
      case (sel)
        REG_CMD: begin
          code = wd[2:0];
          irq_en = wd[CMD_IRQ_EN_BIT];
          if (bus_en && active_cmd == CMD_IDLE && num_phases(code) != 5'd0) begin
            active_cmd = cmd_t'(code);
            phase_cnt = 8'd0;
            bit_ph = 5'd0;
            set_levels(active_cmd, 5'd0);
          end
        end
        REG_STATUS: begin
          ack_tx = wd[0];
          done = wd[STATUS_DONE_BIT];
        end
        REG_TX: tx_byte = wd;
        default: begin
        end
      endcase
    end
    r.read_data = rd;
    r.scl_drive_low = bus_en && !scl_lvl;
    r.sda_drive_low = bus_en && !sda_lvl;
    r.irq = done && irq_en;
  endtask

  always @(posedge clk) begin : monitor
    res_t want;
    res_t got;
    if (rst) begin
      bus_en = 1'b0;
      speed = 6'd0;
      active_cmd = CMD_IDLE;
      irq_en = 1'b0;
      phase_cnt = 8'd0;
      bit_ph = 5'd0;
      tx_byte = 8'd0;
      rx_shift = 8'd0;
      done = 1'b0;
      ack_tx = 1'b0;
      ack_rx = 1'b0;
      scl_lvl = 1'b1;
      sda_lvl = 1'b1;
      engine_outputs_q.delete();
      mismatches = 0;
      outstanding <= 0;
    end else begin
      // pop before push so a beat never meets its own prediction
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[10:0];
        if (engine_outputs_q.size() == 0) begin
          $error("output beat with nothing expected: tdata %0h", m_axis_tdata);
          mismatches++;
        end else begin
          want = engine_outputs_q.pop_front();
          if (got.read_data !== want.read_data) begin
            $error("read_data: expected %0h, got %0h", want.read_data, got.read_data);
            mismatches++;
          end
          if (got.scl_drive_low !== want.scl_drive_low) begin
            $error("scl_drive_low: expected %0b, got %0b",
                   want.scl_drive_low, got.scl_drive_low);
            mismatches++;
          end
          if (got.sda_drive_low !== want.sda_drive_low) begin
            $error("sda_drive_low: expected %0b, got %0b",
                   want.sda_drive_low, got.sda_drive_low);
            mismatches++;
          end
          if (got.irq !== want.irq) begin
            $error("irq: expected %0b, got %0b", want.irq, got.irq);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BUS_ENABLE) bus_en = cfg_data[0];
        else if (cfg_index == CFG_SPEED) speed = cfg_data[5:0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        engine_step(s_axis_tuser[1:0], s_axis_tuser[3:2], s_axis_tdata[7:0],
                    s_axis_tdata[8], want);
        engine_outputs_q.push_back(want);
      end
      outstanding <= engine_outputs_q.size();
    end
  end

endmodule

// ----- dv/tb_i2c_master_command_engine_unit.sv -----
// testbench top for the i2c master command engine: drives register accesses,
// bus transfers and config writes with random stalls, checker judges the outputs
// depends on i2cm_pkg, i2c_master_command_engine_unit and i2cm_engine_checker
`timescale 1ns / 1ps

module tb_i2c_master_command_engine_unit;
  import i2cm_pkg::*;

  localparam logic [1:0] REQ_SPARE     = 2'd3;  // behaves as a plain tick
  localparam logic [2:0] CODE_RESERVED = 3'd7;
  localparam int         STALL_LIMIT   = 2000;
  localparam int         HOLD_CYCLES   = 120;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [7:0] write_data, [8] sda_in
  logic [3:0]  s_axis_tuser;   // [1:0] req_type, [3:2] reg_select
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [7:0] read_data, [8] scl_drive_low,
                               // [9] sda_drive_low, [10] irq
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [7:0]  cfg_data;

  int mismatches;
  int outstanding;

  int tx_idle_pct = 12;
  int rx_idle_pct = 64;
  int cur_speed = 0;
  int n_items = 0;
  int stall_cycles = 0;
  int hold_left = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  i2c_master_command_engine_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  i2cm_engine_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  // result side: random stalls plus one long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // ends the run when no channel moves a beat for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_item(input logic [1:0] req, input logic [1:0] sel,
                           input logic [7:0] wd, input logic sda);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, sda, wd};
    s_axis_tuser <= {sel, req};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    n_items++;
  endtask

  // wait until every expected beat is back and the pipeline has settled
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [7:0] idx, input logic [7:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // filler beat while a command runs: mostly ticks, some accesses
  task automatic busy_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) send_item(REQ_TICK, 2'($urandom), 8'($urandom), 1'($urandom));
    else if (r < 62) send_item(REQ_SPARE, 2'($urandom), 8'($urandom), 1'($urandom));
    else if (r < 80) send_item(REQ_READ, 2'($urandom), 8'($urandom), 1'($urandom));
    else if (r < 88) send_item(REQ_WRITE, REG_TX, 8'($urandom), 1'($urandom));
    else if (r < 92) send_item(REQ_WRITE, REG_STATUS, 8'($urandom), 1'($urandom));
    else if (r < 96) send_item(REQ_WRITE, REG_CMD, 8'($urandom), 1'($urandom));
    else send_item(REQ_WRITE, REG_RX, 8'($urandom), 1'($urandom));
  endtask

  task automatic run_command(input logic [2:0] code);
    int phases;
    int n;
    case (code)
      CMD_START, CMD_STOP: phases = 3;
      CMD_SEND, CMD_RECV:  phases = 16;
      CMD_RACK, CMD_SACK:  phases = 2;
      default:             phases = 0;
    endcase
    send_item(REQ_WRITE, REG_CMD, {1'($urandom), 4'($urandom), code}, 1'($urandom));
    n = phases * (2 * cur_speed + 4) + $urandom_range(0, 5);
    repeat (n) busy_item();
  endtask

  // start, address byte, then data bytes each way, then stop
  task automatic run_transfer();
    int nbytes;
    send_item(REQ_WRITE, REG_STATUS, 8'd0, 1'($urandom));
    run_command(CMD_START);
    send_item(REQ_WRITE, REG_TX, 8'($urandom), 1'($urandom));
    run_command(CMD_SEND);
    run_command(CMD_RACK);
    nbytes = $urandom_range(1, 2);
    repeat (nbytes) begin
      if ($urandom_range(0, 1) == 1) begin
        run_command(CMD_RECV);
        send_item(REQ_READ, REG_RX, 8'($urandom), 1'($urandom));
        send_item(REQ_WRITE, REG_STATUS, {1'b0, 1'($urandom), 5'd0, 1'($urandom)},
                  1'($urandom));
        run_command(CMD_SACK);
      end else begin
        send_item(REQ_WRITE, REG_TX, 8'($urandom), 1'($urandom));
        run_command(CMD_SEND);
        run_command(CMD_RACK);
      end
      send_item(REQ_READ, REG_STATUS, 8'($urandom), 1'($urandom));
    end
    run_command(CMD_STOP);
  endtask

  task automatic random_sequence();
    int r;
    logic [2:0] code;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      run_transfer();
    end else if (r < 88) begin
      code = 3'($urandom_range(CMD_START, CMD_STOP));
      if (code == CMD_SEND) send_item(REQ_WRITE, REG_TX, 8'($urandom), 1'($urandom));
      if (code == CMD_SACK) send_item(REQ_WRITE, REG_STATUS, 8'($urandom), 1'($urandom));
      run_command(code);
      send_item(REQ_READ, REG_STATUS, 8'($urandom), 1'($urandom));
      send_item(REQ_READ, REG_RX, 8'($urandom), 1'($urandom));
    end else begin
      // unstructured beats, reserved command codes included
      repeat ($urandom_range(1, 8))
        send_item(2'($urandom), 2'($urandom), 8'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    int target;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // bus still disabled: reset values, command start ignored
    send_item(REQ_READ, REG_CMD, 8'h00, 1'b0);
    send_item(REQ_READ, REG_STATUS, 8'hFF, 1'b1);
    send_item(REQ_READ, REG_TX, 8'h00, 1'b0);
    send_item(REQ_READ, REG_RX, 8'hFF, 1'b1);
    send_item(REQ_WRITE, REG_CMD, {1'b1, 4'd0, CMD_START}, 1'b0);
    send_item(REQ_READ, REG_CMD, 8'h00, 1'b1);

    write_cfg(CFG_BUS_ENABLE, 8'd1);
    write_cfg(CFG_SPEED, 8'd0);
    send_item(REQ_WRITE, REG_TX, 8'hFF, 1'b1);
    send_item(REQ_WRITE, REG_RX, 8'hAA, 1'b0);
    send_item(REQ_READ, REG_RX, 8'h00, 1'b0);
    send_item(REQ_WRITE, REG_CMD, {1'b0, 4'd0, CMD_IDLE}, 1'b0);
    send_item(REQ_WRITE, REG_CMD, {1'b1, 4'hF, CODE_RESERVED}, 1'b1);
    send_item(REQ_READ, REG_STATUS, 8'h00, 1'b0);
    send_item(REQ_WRITE, REG_STATUS, 8'hFF, 1'b0);
    send_item(REQ_SPARE, REG_CMD, 8'hFF, 1'b1);
    send_item(REQ_WRITE, REG_STATUS, 8'h00, 1'b0);

    // command while busy, transmit rewrite mid-byte, then bus disabled mid-command
    send_item(REQ_WRITE, REG_CMD, {1'b1, 4'd0, CMD_SEND}, 1'b0);
    send_item(REQ_WRITE, REG_CMD, {1'b0, 4'd0, CMD_STOP}, 1'b1);
    send_item(REQ_WRITE, REG_TX, 8'h00, 1'b0);
    send_item(REQ_TICK, REG_CMD, 8'h00, 1'b1);
    send_item(REQ_READ, REG_STATUS, 8'h00, 1'b0);
    send_item(REQ_TICK, REG_TX, 8'hFF, 1'b1);
    write_cfg(CFG_BUS_ENABLE, 8'd0);
    send_item(REQ_READ, REG_STATUS, 8'h00, 1'b0);
    send_item(REQ_READ, REG_CMD, 8'h00, 1'b1);
    send_item(REQ_TICK, REG_STATUS, 8'h00, 1'b0);
    write_cfg(CFG_BUS_ENABLE, 8'd1);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 12;
          rx_idle_pct = 64;
          cur_speed = 0;
        end
        1: begin
          tx_idle_pct = 64;
          rx_idle_pct = 12;
          cur_speed = $urandom_range(1, 3);
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          cur_speed = 0;
        end
      endcase
      write_cfg(CFG_SPEED, 8'(cur_speed));
      // fill the pipeline against a stalled receiver
      if (ph == 2) hold_req <= 1'b1;
      // a sequence runs to its end, so each phase overshoots its share
      target = n_items + 80;
      while (n_items < target) random_sequence();
    end

    // slowest bus setting, one short command
    cur_speed = 63;
    write_cfg(CFG_SPEED, 8'(cur_speed));
    run_command(CMD_RACK);
    send_item(REQ_READ, REG_STATUS, 8'h00, 1'b0);
    write_cfg(CFG_BUS_ENABLE, 8'd0);
    repeat (8) send_item(2'($urandom), 2'($urandom), 8'($urandom), 1'($urandom));

    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_core.sv
hw/rtl/i2c_master_command_engine_unit.sv
dv/i2cm_engine_checker.sv
dv/tb_i2c_master_command_engine_unit.sv
